// File: sv/edd_pkg.sv
// Shared types and constants of the RGB565 error-diffusion dither.
// No dependencies; the front, back and top files refer to it by scoped names.
package edd_pkg;

   // Defaults for the size parameters of the top level.
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Sample, level and error widths.
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 5;
   localparam int ERR_W    = 11;
   localparam int CHAN     = 3;
   localparam int PIXEL_W  = 16;

   // Configuration port.
   localparam int SIZE_W      = 13;
   localparam int GAMMA_W     = 40;
   localparam int GAMMA_REGS  = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_0      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_1      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_2      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_3      = 3'd5;

   localparam logic [SIZE_W-1:0]  SIZE_RESET    = 13'd4096;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET_0 = 40'd247132686368;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET_1 = 40'd530877622568;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET_2 = 40'd814622558768;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET_3 = 40'd1098367494968;

   // Queue depths between the parts.
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // All four gamma registers side by side, register 0 in the low bits.
   typedef logic [GAMMA_REGS*GAMMA_W-1:0] gamma_tbl_type;

   // Raster position flags of one pixel.
   typedef struct packed {
      logic first_col;
      logic last_col;
      logic first_row;
      logic last_row;
   } pos_type;

   // One classified pixel as it travels from the front to the back.
   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      pos_type             pos;
   } pix_type;

endpackage

// File: sv/edd_fifo.sv
// Small register-based first-in first-out queue with occupancy count.
// Standalone; used between front and back and in front of the result port.
module edd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH):0]     count
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/edd_front.sv
// Front part of the dither: accepts pixel words, averages the two greens
// and tags each word with its raster position. Depends on edd_pkg.
module edd_front #(
   parameter int MAX_WIDTH  = edd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = edd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [edd_pkg::SAMPLE_W-1:0]      req_red_in,
   input  logic [edd_pkg::SAMPLE_W-1:0]      req_green_first_in,
   input  logic [edd_pkg::SAMPLE_W-1:0]      req_green_second_in,
   input  logic [edd_pkg::SAMPLE_W-1:0]      req_blue_in,
   input  logic [edd_pkg::SIZE_W-1:0]        image_width,
   input  logic [edd_pkg::SIZE_W-1:0]        image_height,
   output logic                              mid_push,
   output edd_pkg::pix_type                  mid_pix,
   output logic [$clog2(MAX_WIDTH)-1:0]      mid_x,
   input  logic                              mid_full
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CCMP_W = (COL_W + 1 > edd_pkg::SIZE_W) ? COL_W + 1 : edd_pkg::SIZE_W;
   localparam int RCMP_W = (ROW_W + 1 > edd_pkg::SIZE_W) ? ROW_W + 1 : edd_pkg::SIZE_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W:0]   col_next;
   logic [ROW_W:0]   row_next;
   logic             accept;
   edd_pkg::pos_type pos;

   assign accept   = req_push && !mid_full;
   assign req_full = mid_full;
   assign col_next = {1'b0, col_ff} + 1'b1;
   assign row_next = {1'b0, row_ff} + 1'b1;

   // A size of zero behaves as one, and a size above the maximum as the maximum.
   always_comb begin
      pos.first_col = (col_ff == '0);
      pos.first_row = (row_ff == '0);
      pos.last_col  = (image_width == '0) ||
                      (CCMP_W'(col_next) >= CCMP_W'(image_width)) ||
                      (col_ff == COL_W'(MAX_WIDTH - 1));
      pos.last_row  = (image_height == '0) ||
                      (RCMP_W'(row_next) >= RCMP_W'(image_height)) ||
                      (row_ff == ROW_W'(MAX_HEIGHT - 1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (pos.last_col) begin
            col_in = '0;
            row_in = pos.last_row ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign mid_push      = accept;
   assign mid_x         = col_ff;
   assign mid_pix.red   = req_red_in;
   assign mid_pix.green = {1'b0, req_green_first_in[edd_pkg::SAMPLE_W-1:1]} +
                          {1'b0, req_green_second_in[edd_pkg::SAMPLE_W-1:1]};
   assign mid_pix.blue  = req_blue_in;
   assign mid_pix.pos   = pos;

endmodule

// File: sv/edd_back.sv
// Back part of the dither: line store of next-row error, the diffusion stage,
// gamma lookup and RGB565 packing. Depends on edd_pkg.
module edd_back #(
   parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                mid_empty,
   output logic                                mid_pop,
   input  edd_pkg::pix_type                    mid_pix,
   input  logic [$clog2(MAX_WIDTH)-1:0]        mid_x,
   input  edd_pkg::gamma_tbl_type              gamma_tbl,
   output logic                                out_push,
   output logic [edd_pkg::PIXEL_W-1:0]         out_pixel,
   input  logic [$clog2(edd_pkg::OUT_DEPTH):0] out_count
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(edd_pkg::OUT_DEPTH) + 1;
   localparam int ERR_W  = edd_pkg::ERR_W;
   localparam int EW     = ERR_W * edd_pkg::CHAN;
   localparam int LW     = edd_pkg::LEVEL_W;

   // Where the above-row error of the word in the stage comes from.
   localparam logic [1:0] SRC_MEM  = 2'd1;
   localparam logic [1:0] SRC_FWD  = 2'd2;

   logic [EW-1:0]    line_mem [MAX_WIDTH];
   logic [EW-1:0]    rd_ff;

   logic             s1_valid_ff, s1_valid_in;
   edd_pkg::pix_type s1_pix_ff;
   logic [COL_W-1:0] s1_x_ff;
   logic [1:0]       src_ff, src_in;
   logic [EW-1:0]    fwd_ff, fwd_in;

   logic [EW-1:0]    rc_ff, rc_in;
   logic [EW-1:0]    bl_ff, bl_in;
   logic [EW-1:0]    bp_ff, bp_in;

   logic             pend_valid_ff, pend_valid_in;
   logic [COL_W-1:0] pend_addr_ff;
   logic [EW-1:0]    pend_data_ff;
   logic             clr_busy_ff, clr_busy_in;
   logic [COL_W-1:0] clr_addr_ff, clr_addr_in;

   logic [EW-1:0]    above_all;
   logic [EW-1:0]    col_here_all;
   logic [EW-1:0]    left_share_all;
   logic [EW-1:0]    e_share_all;
   logic [EW-1:0]    rc_share_all;
   logic [LW-1:0]    lvl [edd_pkg::CHAN];
   logic [edd_pkg::SAMPLE_W-1:0] chan [edd_pkg::CHAN];

   logic [ERR_W-1:0] above [edd_pkg::CHAN];
   logic [ERR_W-1:0] left  [edd_pkg::CHAN];
   logic [ERR_W-1:0] bl    [edd_pkg::CHAN];
   logic [ERR_W-1:0] bp    [edd_pkg::CHAN];
   logic [17:0]      sum   [edd_pkg::CHAN];
   logic [15:0]      sat   [edd_pkg::CHAN];
   logic [ERR_W-1:0] err   [edd_pkg::CHAN];
   logic [13:0]      e5    [edd_pkg::CHAN];
   logic [12:0]      e3    [edd_pkg::CHAN];
   logic [13:0]      e7    [edd_pkg::CHAN];

   logic             a_en, b_en, mem_we;
   logic [COL_W-1:0] a_addr, mem_waddr;
   logic [EW-1:0]    mem_wdata;

   // Take a word only when the line store is cleared and the result queue has
   // room for it and for the one already in the stage.
   assign mid_pop = !mid_empty && !clr_busy_ff &&
                    (({1'b0, out_count} + (CNT_W+1)'(s1_valid_ff)) <
                     (CNT_W+1)'(edd_pkg::OUT_DEPTH));

   assign chan[0] = s1_pix_ff.red;
   assign chan[1] = s1_pix_ff.green;
   assign chan[2] = s1_pix_ff.blue;

   always_comb begin
      case (src_ff)
         SRC_FWD: above_all = fwd_ff;
         SRC_MEM: above_all = rd_ff;
         default: above_all = '0;
      endcase
   end

   always_comb begin
      for (int c = 0; c < edd_pkg::CHAN; c++) begin
         above[c] = s1_pix_ff.pos.first_row ? '0 : above_all[c*ERR_W +: ERR_W];
         left[c]  = s1_pix_ff.pos.first_col ? '0 : rc_ff[c*ERR_W +: ERR_W];
         bl[c]    = s1_pix_ff.pos.first_col ? '0 : bl_ff[c*ERR_W +: ERR_W];
         bp[c]    = s1_pix_ff.pos.first_col ? '0 : bp_ff[c*ERR_W +: ERR_W];
         sum[c]   = {2'b00, chan[c]} + 18'(above[c]) + 18'(left[c]);
         sat[c]   = (sum[c][17:16] != 2'b00) ? 16'hFFFF : sum[c][15:0];
         lvl[c]   = sat[c][15:11];
         err[c]   = sat[c][10:0];
         e5[c]    = {1'b0, err[c], 2'b00} + {3'b000, err[c]};
         e3[c]    = {1'b0, err[c], 1'b0} + {2'b00, err[c]};
         e7[c]    = {err[c], 3'b000} - {3'b000, err[c]};
         col_here_all[c*ERR_W +: ERR_W]   = bp[c] + {1'b0, e5[c][13:4]};
         left_share_all[c*ERR_W +: ERR_W] = bl[c] + {2'b00, e3[c][12:4]};
         e_share_all[c*ERR_W +: ERR_W]    = {4'b0000, err[c][10:4]};
         rc_share_all[c*ERR_W +: ERR_W]   = {1'b0, e7[c][13:4]};
      end
   end

   // Below-left share goes to the previous column; at the row end the below
   // share of the last column waits in the pending register.
   assign a_en   = s1_valid_ff && !s1_pix_ff.pos.last_row && !s1_pix_ff.pos.first_col;
   assign b_en   = s1_valid_ff && !s1_pix_ff.pos.last_row && s1_pix_ff.pos.last_col;
   assign a_addr = s1_x_ff - 1'b1;

   // After reset the write port zeroes every entry once, one per cycle.
   assign mem_we    = clr_busy_ff || a_en || pend_valid_ff;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : (a_en ? a_addr : pend_addr_ff);
   assign mem_wdata = clr_busy_ff ? '0 : (a_en ? left_share_all : pend_data_ff);

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_in = 1'b0;
            clr_addr_in = '0;
         end
      end
   end

   // The read issued now must see the writes of the word in the stage.
   always_comb begin
      src_in = SRC_MEM;
      fwd_in = col_here_all;
      if (b_en && (s1_x_ff == mid_x)) begin
         src_in = SRC_FWD;
         fwd_in = col_here_all;
      end else if (a_en && (a_addr == mid_x)) begin
         src_in = SRC_FWD;
         fwd_in = left_share_all;
      end else if (pend_valid_ff && (pend_addr_ff == mid_x)) begin
         src_in = SRC_FWD;
         fwd_in = pend_data_ff;
      end
   end

   always_comb begin
      rc_in = rc_ff;
      bl_in = bl_ff;
      bp_in = bp_ff;
      if (s1_valid_ff) begin
         if (s1_pix_ff.pos.last_col) begin
            rc_in = '0;
            bl_in = '0;
            bp_in = '0;
         end else begin
            rc_in = rc_share_all;
            bl_in = col_here_all;
            bp_in = e_share_all;
         end
      end
   end

   assign s1_valid_in   = mid_pop;
   assign pend_valid_in = b_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         rc_ff         <= '0;
         bl_ff         <= '0;
         bp_ff         <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         pend_valid_ff <= pend_valid_in;
         clr_busy_ff   <= clr_busy_in;
         clr_addr_ff   <= clr_addr_in;
         rc_ff         <= rc_in;
         bl_ff         <= bl_in;
         bp_ff         <= bp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_pix_ff <= mid_pix;
         s1_x_ff   <= mid_x;
         src_ff    <= src_in;
         fwd_ff    <= fwd_in;
      end
      if (b_en) begin
         pend_addr_ff <= s1_x_ff;
         pend_data_ff <= col_here_all;
      end
   end

   // Line store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (mid_pop) begin
         rd_ff <= line_mem[mid_x];
      end
   end

   function automatic logic [LW-1:0] gamma_map(input edd_pkg::gamma_tbl_type tbl,
                                                 input logic [LW-1:0] level);
      gamma_map = tbl[LW*level +: LW];
   endfunction

   assign out_push  = s1_valid_ff;
   assign out_pixel = {gamma_map(gamma_tbl, lvl[0]), gamma_map(gamma_tbl, lvl[1]), 1'b0,
                       gamma_map(gamma_tbl, lvl[2])};

   assert property (@(posedge clock) disable iff (reset) !(a_en && pend_valid_ff))
      else $error("line store write collision between pending and below-left share");

   assert property (@(posedge clock) disable iff (reset)
                    s1_valid_ff |-> (out_count < edd_pkg::OUT_DEPTH))
      else $error("result queue has no room for the word in the stage");

   assert property (@(posedge clock) disable iff (reset)
                    clr_busy_ff |-> (!s1_valid_ff && !pend_valid_ff))
      else $error("line store written by a word during the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
                    (s1_valid_ff && s1_pix_ff.pos.last_col) ##1 s1_valid_ff
                    |-> s1_pix_ff.pos.first_col)
      else $error("word after a row end is not at the first column");

endmodule

// File: sv/error_diffusion_dither_rgb565.sv
// Top level of the RGB565 error-diffusion dither, with its register file.
// Depends on edd_pkg, edd_fifo, edd_front and edd_back.
//
// Takes one raster-ordered pixel word per clock while req_full is low and
// returns one RGB565 word per pixel, in order, at a sustained rate of one per
// cycle while results are popped; a pixel passes the middle queue, the
// diffusion stage and the result queue. The rate is set by the single
// diffusion stage, whose registered right-neighbor error feeds the next pixel,
// and by the line store of MAX_WIDTH entries with one write and one read port.
// After reset the line store is zeroed in a clearing pass over all MAX_WIDTH
// entries; up to MID_DEPTH words are accepted meanwhile, then req_full stays
// high until the pass ends. Size and gamma registers are to be written only
// while the block is idle, which it does not enforce; a size of zero acts as
// one and a size above the maximum as the maximum. Results wait in a short
// queue, so input keeps flowing while a finished word is not yet popped.
module error_diffusion_dither_rgb565 #(
   parameter int MAX_WIDTH  = edd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = edd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [edd_pkg::SAMPLE_W-1:0]       req_red_in,
   input  logic [edd_pkg::SAMPLE_W-1:0]       req_green_first_in,
   input  logic [edd_pkg::SAMPLE_W-1:0]       req_green_second_in,
   input  logic [edd_pkg::SAMPLE_W-1:0]       req_blue_in,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [edd_pkg::PIXEL_W-1:0]        rsp_pixel_565,
   input  logic                               csr_write,
   input  logic [edd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [edd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int MID_W = COL_W + $bits(edd_pkg::pix_type);
   localparam int GW    = edd_pkg::GAMMA_W;

   logic [edd_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [edd_pkg::SIZE_W-1:0] height_ff, height_in;
   edd_pkg::gamma_tbl_type     gamma_ff, gamma_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      gamma_in  = gamma_ff;
      if (csr_write) begin
         case (csr_index)
            edd_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_data[edd_pkg::SIZE_W-1:0];
            edd_pkg::CSR_IMAGE_HEIGHT: height_in = csr_data[edd_pkg::SIZE_W-1:0];
            edd_pkg::CSR_GAMMA_0:      gamma_in[0*GW +: GW] = csr_data[GW-1:0];
            edd_pkg::CSR_GAMMA_1:      gamma_in[1*GW +: GW] = csr_data[GW-1:0];
            edd_pkg::CSR_GAMMA_2:      gamma_in[2*GW +: GW] = csr_data[GW-1:0];
            edd_pkg::CSR_GAMMA_3:      gamma_in[3*GW +: GW] = csr_data[GW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= edd_pkg::SIZE_RESET;
         height_ff <= edd_pkg::SIZE_RESET;
         gamma_ff  <= {edd_pkg::GAMMA_RESET_3, edd_pkg::GAMMA_RESET_2,
                       edd_pkg::GAMMA_RESET_1, edd_pkg::GAMMA_RESET_0};
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         gamma_ff  <= gamma_in;
      end
   end

   logic                       mid_push, mid_full, mid_pop, mid_empty;
   edd_pkg::pix_type           front_pix, back_pix;
   logic [COL_W-1:0]           front_x, back_x;
   logic [$clog2(edd_pkg::MID_DEPTH):0] mid_count;

   logic                       out_push, out_full;
   logic [edd_pkg::PIXEL_W-1:0] out_pixel;
   logic [$clog2(edd_pkg::OUT_DEPTH):0] out_count;

   edd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_red_in          (req_red_in),
      .req_green_first_in  (req_green_first_in),
      .req_green_second_in (req_green_second_in),
      .req_blue_in         (req_blue_in),
      .image_width         (width_ff),
      .image_height        (height_ff),
      .mid_push            (mid_push),
      .mid_pix             (front_pix),
      .mid_x               (front_x),
      .mid_full            (mid_full)
   );

   edd_fifo #(
      .WIDTH (MID_W),
      .DEPTH (edd_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data ({front_x, front_pix}),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  ({back_x, back_pix}),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   edd_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_pix   (back_pix),
      .mid_x     (back_x),
      .gamma_tbl (gamma_ff),
      .out_push  (out_push),
      .out_pixel (out_pixel),
      .out_count (out_count)
   );

   edd_fifo #(
      .WIDTH (edd_pkg::PIXEL_W),
      .DEPTH (edd_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_pixel),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_pixel_565),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   // The back part only takes a word when the result queue has room for it.
   assert property (@(posedge clock) disable iff (reset) out_push |-> !out_full)
      else $error("result word pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
                    mid_count <= edd_pkg::MID_DEPTH)
      else $error("middle queue count beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
                    (csr_write && (csr_index == edd_pkg::CSR_IMAGE_WIDTH))
                    |=> (width_ff == $past(csr_data[edd_pkg::SIZE_W-1:0])))
      else $error("image width register did not take the write");

endmodule
